### src/brel_pkg.sv
// ----------------------------------------------------------------------------
// Binned range efficiency lookup package
// Shared types, operation and variant codes, and the bin test functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brel_pkg;

	localparam int unsigned MAX_ENTRIES_DEF = 64;

	// Fallback pt point after reset: 350.0 in Q12.4.
	localparam logic [15:0] FALLBACK_PT_RST = 16'd5600;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] VAR_NOMINAL = 2'd0;
	localparam logic [1:0] VAR_LOW     = 2'd1;
	localparam logic [1:0] VAR_HIGH    = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic        [15:0] pt_lo;
		logic        [15:0] pt_hi;
		logic signed [11:0] eta_lo;
		logic signed [11:0] eta_hi;
	} bound_t;

	typedef struct packed {
		logic [15:0] eff;
		logic [15:0] err_lo;
		logic [15:0] err_hi;
	} value_t;

	// True when the half-open eta range of the record holds eta.
	function automatic logic eta_in(bound_t b, logic signed [11:0] eta);
		logic signed [11:0] lo;
		logic signed [11:0] hi;
		lo = b.eta_lo;
		hi = b.eta_hi;
		return (eta >= lo) && (eta < hi);
	endfunction

	// True when the record's bin holds the point (pt, eta).
	function automatic logic bin_holds(bound_t b, logic [15:0] pt, logic signed [11:0] eta);
		return (pt >= b.pt_lo) && (pt < b.pt_hi) && eta_in(b, eta);
	endfunction

endpackage

### src/binned_range_efficiency_lookup_core.sv
// ----------------------------------------------------------------------------
// Binned range efficiency lookup core
// Clear and append items, and the unused operation code, are answered at once.
// A query item scans the stored records in order and ends at the first one
// that holds the point, or once every record has been tested; an empty table
// ends the scan at once.
// The scan compares one record a cycle against a memory read port, and no new
// item is taken until the result is accepted.
// Reset (arst_n low) empties the table and sets fallback_pt to 350.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binned_range_efficiency_lookup_core
	import brel_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	// Configuration write channel: the fallback pt register.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [15:0] cfg_data,

	// Input item channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [1:0]  operation,
	input  logic        [15:0] bin_pt_low,
	input  logic        [15:0] bin_pt_high,
	input  logic signed [11:0] bin_eta_low,
	input  logic signed [11:0] bin_eta_high,
	input  logic        [15:0] bin_efficiency,
	input  logic        [15:0] bin_error_low,
	input  logic        [15:0] bin_error_high,
	input  logic        [15:0] query_pt,
	input  logic signed [11:0] query_eta,
	input  logic        [1:0]  variant,

	// Result item channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [15:0] value,
	output logic               exact_hit,
	output logic               table_full,
	output logic               saturated
);

	// Index width covers the table depth; the count also holds the depth itself.
	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	// Record storage. Entries are written by append items and read only by
	// the scan, and only below the fill count, so no entry needs a valid bit.
	bound_t bound_mem [MAX_ENTRIES];
	value_t value_mem [MAX_ENTRIES];

	state_t state_q, state_next;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	logic [15:0]      fallback_q;

	// Query operands, held for the whole scan, and the running fallback value.
	logic        [15:0] qpt_q;
	logic signed [11:0] qeta_q;
	logic        [1:0]  qvar_q;
	logic        [15:0] fb_q;

	// Registered memory read and its tag.
	bound_t rd_bound_s1;
	value_t rd_value_s1;
	logic   rd_vld_s1;

	// Result register.
	logic        out_valid_q;
	logic [15:0] value_q;
	logic        hit_q;
	logic        full_q;
	logic        sat_q;

	logic        in_accept;
	logic        issue;
	logic        hit_s1;
	logic        fb_match;
	logic        scan_done;
	logic        adj_lo;
	logic        adj_hi;
	logic [16:0] sum_hi;
	logic [16:0] diff_lo;
	logic [15:0] adj_value;
	logic        adj_sat;

	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// The scan issues one read a cycle while records remain.
	assign issue = (state_q == ST_SCAN) && (issue_q < count_q);

	assign adj_lo = (qvar_q == VAR_LOW);
	assign adj_hi = (qvar_q == VAR_HIGH);

	// The compare unit: the record read last cycle is tested against the query
	// point and, in parallel, against the fallback rule of the variant.
	always_comb begin
		hit_s1 = rd_vld_s1 && bin_holds(rd_bound_s1, qpt_q, qeta_q);
		if (adj_lo || adj_hi) begin
			fb_match = bin_holds(rd_bound_s1, fallback_q, qeta_q);
		end else begin
			fb_match = (rd_bound_s1.pt_lo < rd_bound_s1.pt_hi) &&
				eta_in(rd_bound_s1, qeta_q);
		end
	end

	// Error adjustment of the hit record, clipped at zero or full scale.
	always_comb begin
		sum_hi  = {1'b0, rd_value_s1.eff} + {1'b0, rd_value_s1.err_hi};
		diff_lo = {1'b0, rd_value_s1.eff} - {1'b0, rd_value_s1.err_lo};
		adj_value = rd_value_s1.eff;
		adj_sat   = 1'b0;
		if (adj_lo) begin
			adj_value = diff_lo[16] ? 16'd0 : diff_lo[15:0];
			adj_sat   = diff_lo[16];
		end else if (adj_hi) begin
			adj_value = sum_hi[16] ? 16'hFFFF : sum_hi[15:0];
			adj_sat   = sum_hi[16];
		end
	end

	// The scan ends on the first hit, or once every record has been tested.
	assign scan_done = (state_q == ST_SCAN) && (hit_s1 || (!rd_vld_s1 && !issue));

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && operation == OP_QUERY) begin
					state_next = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Handshake outputs. An item is taken only when the result register is
	// free or is being emptied in the same cycle.
	always_comb begin
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: in_stall = out_valid_q && out_stall;
			ST_SCAN: in_stall = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			fallback_q <= FALLBACK_PT_RST;
			rd_vld_s1  <= 1'b0;
		end else begin
			state_q   <= state_next;
			rd_vld_s1 <= issue && !scan_done;
			if (cfg_valid && cfg_ready) begin
				fallback_q <= cfg_data;
			end
			if (issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (in_accept) begin
				issue_q <= '0;
				unique case (operation)
					OP_CLEAR: count_q <= '0;
					OP_APPEND: begin
						if (count_q < CNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Memory write on append and registered read for the scan.
	always_ff @(posedge clk) begin
		if (in_accept && operation == OP_APPEND && count_q < CNT_MAX) begin
			bound_mem[count_q[IDX_W-1:0]] <= '{pt_lo: bin_pt_low, pt_hi: bin_pt_high,
				eta_lo: bin_eta_low, eta_hi: bin_eta_high};
			value_mem[count_q[IDX_W-1:0]] <= '{eff: bin_efficiency,
				err_lo: bin_error_low, err_hi: bin_error_high};
		end
		rd_bound_s1 <= bound_mem[issue_q[IDX_W-1:0]];
		rd_value_s1 <= value_mem[issue_q[IDX_W-1:0]];
	end

	// Query operands and the running fallback value. The last matching record
	// wins, so the fallback register is simply overwritten on every match.
	always_ff @(posedge clk) begin
		if (in_accept && operation == OP_QUERY) begin
			qpt_q  <= query_pt;
			qeta_q <= query_eta;
			qvar_q <= variant;
			fb_q   <= '0;
		end else if (rd_vld_s1 && !hit_s1 && fb_match && state_q == ST_SCAN) begin
			fb_q <= rd_value_s1.eff;
		end
	end

	// Result register. Every item other than a query answers at once; a query
	// answers when its scan ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept && operation != OP_QUERY) begin
				out_valid_q <= 1'b1;
			end else if (scan_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && operation != OP_QUERY) begin
			value_q <= '0;
			hit_q   <= 1'b0;
			sat_q   <= 1'b0;
			full_q  <= (operation == OP_APPEND) && (count_q >= CNT_MAX);
		end else if (scan_done) begin
			value_q <= hit_s1 ? adj_value : fb_q;
			hit_q   <= hit_s1;
			sat_q   <= hit_s1 && adj_sat;
			full_q  <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign exact_hit  = hit_q;
	assign table_full = full_q;
	assign saturated  = sat_q;

	// The fill count never passes the table depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_MAX)
		else $error("entry count exceeds table depth");

	// Only a query item starts a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && operation != OP_QUERY |=> state_q == ST_IDLE)
		else $error("scan started by a non-query item");

	// A clipped value only comes from a record that held the point.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sat_q |-> hit_q && !full_q)
		else $error("saturation flagged without an exact hit");

	// A scan never reads past the records that were written.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> issue_q <= count_q)
		else $error("scan read beyond the fill count");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Binned range efficiency lookup testbench
// Drives clear, append and query items through the core with random idling
// on both channels. A behavioral table predicts every result, and each result
// is checked field by field. The fallback pt register is rewritten between
// traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import brel_pkg::*;

	localparam int unsigned TABLE_DEPTH = MAX_ENTRIES_DEF;

	// Codes outside the package: the core answers operation 3 with an all-zero
	// result and leaves the table alone, and treats variant 3 as the nominal lookup.
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam logic [1:0] VAR_ALT    = 2'd3;

	// One input item, laid out as the core's input ports.
	typedef struct packed {
		logic        [1:0]  operation;
		logic        [15:0] pt_low;
		logic        [15:0] pt_high;
		logic signed [11:0] eta_low;
		logic signed [11:0] eta_high;
		logic        [15:0] efficiency;
		logic        [15:0] error_low;
		logic        [15:0] error_high;
		logic        [15:0] pt;
		logic signed [11:0] eta;
		logic        [1:0]  variant;
	} lookup_item_t;

	typedef struct packed {
		logic [15:0] value;
		logic        exact_hit;
		logic        table_full;
		logic        saturated;
	} lookup_result_t;

	// A stored bin, held as plain integers so that every comparison is exact.
	typedef struct {
		int pt_lo;
		int pt_hi;
		int eta_lo;
		int eta_hi;
		int eff;
		int err_lo;
		int err_hi;
	} bin_rec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic        [15:0] cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	lookup_item_t       drive_item = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [15:0] value;
	logic               exact_hit;
	logic               table_full;
	logic               saturated;

	// Item queued for the driver, expected lookup answers, and bookkeeping.
	lookup_item_t   item_backlog[$];
	lookup_result_t lookup_answers[$];
	lookup_result_t oldest_answer;
	logic           item_taken = 1'b0;
	int             items_issued = 0;
	int             items_accepted = 0;
	int             stimulus_count = 0;
	int             error_count = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;

	// Behavioral copy of the table, its fill level and the fallback register.
	bin_rec_t    model_bins[TABLE_DEPTH];
	int          model_count = 0;
	logic [15:0] model_fallback = FALLBACK_PT_RST;

	// Bins appended since the last clear, used only to aim query points.
	bin_rec_t gen_bins[$];

	logic [1:0] op_codes[4]      = '{OP_CLEAR, OP_APPEND, OP_QUERY, OP_IGNORED};
	logic [1:0] variant_codes[4] = '{VAR_NOMINAL, VAR_LOW, VAR_HIGH, VAR_ALT};

	binned_range_efficiency_lookup_core #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (drive_item.operation),
		.bin_pt_low    (drive_item.pt_low),
		.bin_pt_high   (drive_item.pt_high),
		.bin_eta_low   (drive_item.eta_low),
		.bin_eta_high  (drive_item.eta_high),
		.bin_efficiency(drive_item.efficiency),
		.bin_error_low (drive_item.error_low),
		.bin_error_high(drive_item.error_high),
		.query_pt      (drive_item.pt),
		.query_eta     (drive_item.eta),
		.variant       (drive_item.variant),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.exact_hit     (exact_hit),
		.table_full    (table_full),
		.saturated     (saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is held low from time zero and released on a falling edge.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Safety net: the slowest legal run finishes far earlier than this.
	initial begin
		#(5_000_000);
		$display("tb: errors");
		$finish;
	end

	function automatic int clip(int x, int lo, int hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	// Half-open test on both axes.
	function automatic bit bin_covers(bin_rec_t b, int pt, int eta);
		return pt >= b.pt_lo && pt < b.pt_hi && eta >= b.eta_lo && eta < b.eta_hi;
	endfunction

	// Applies one item to the behavioral table and returns the answer the
	// core must give for it. A query walks the bins in load order and stops
	// at the first one that holds the point. While walking, it remembers the
	// last bin that qualifies as a fallback: for the nominal lookup that is
	// any bin with a non-empty pt range whose eta range holds the point; for
	// the low and high lookups it is a bin holding (fallback pt, eta).
	function automatic lookup_result_t lookup_efficiency(lookup_item_t it);
		lookup_result_t res;
		bin_rec_t       b;
		int             pt;
		int             eta;
		int             fb;
		int             i;
		bit             found;
		res = '0;
		fb = 0;
		found = 1'b0;
		pt = int'(it.pt);
		eta = int'($signed(it.eta));
		case (it.operation)
			OP_CLEAR: begin
				model_count = 0;
			end
			OP_APPEND: begin
				if (model_count >= TABLE_DEPTH) begin
					res.table_full = 1'b1;
				end else begin
					b.pt_lo = int'(it.pt_low);
					b.pt_hi = int'(it.pt_high);
					b.eta_lo = int'($signed(it.eta_low));
					b.eta_hi = int'($signed(it.eta_high));
					b.eff = int'(it.efficiency);
					b.err_lo = int'(it.error_low);
					b.err_hi = int'(it.error_high);
					model_bins[model_count] = b;
					model_count++;
				end
			end
			OP_QUERY: begin
				for (i = 0; i < model_count && !found; i++) begin
					b = model_bins[i];
					if (bin_covers(b, pt, eta)) begin
						found = 1'b1;
						res.exact_hit = 1'b1;
						if (it.variant == VAR_LOW) begin
							if (b.err_lo > b.eff) begin
								res.saturated = 1'b1;
							end else begin
								res.value = 16'(b.eff - b.err_lo);
							end
						end else if (it.variant == VAR_HIGH) begin
							if (b.eff + b.err_hi > 65535) begin
								res.value = '1;
								res.saturated = 1'b1;
							end else begin
								res.value = 16'(b.eff + b.err_hi);
							end
						end else begin
							res.value = 16'(b.eff);
						end
					end else if (it.variant == VAR_LOW || it.variant == VAR_HIGH) begin
						if (bin_covers(b, int'(model_fallback), eta))
							fb = b.eff;
					end else if (b.pt_lo < b.pt_hi && eta >= b.eta_lo && eta < b.eta_hi) begin
						fb = b.eff;
					end
				end
				if (!found)
					res.value = 16'(fb);
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Sender. The payload only changes after the previous item was taken, and
	// valid is raised or dropped without looking at the stall line.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || item_taken) begin
				if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_item <= item_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, redrawn every cycle.
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor for both channels. The result check runs before the new
	// expectation is queued, so an answer can never be matched against the
	// item accepted on the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (lookup_answers.size() == 0) begin
					$error("unexpected result item: value %0d", value);
					error_count++;
				end else begin
					oldest_answer = lookup_answers.pop_front();
					if (value !== oldest_answer.value) begin
						$error("value: expected %0d, actual %0d", oldest_answer.value, value);
						error_count++;
					end
					if (exact_hit !== oldest_answer.exact_hit) begin
						$error("exact_hit: expected %0d, actual %0d",
							oldest_answer.exact_hit, exact_hit);
						error_count++;
					end
					if (table_full !== oldest_answer.table_full) begin
						$error("table_full: expected %0d, actual %0d",
							oldest_answer.table_full, table_full);
						error_count++;
					end
					if (saturated !== oldest_answer.saturated) begin
						$error("saturated: expected %0d, actual %0d",
							oldest_answer.saturated, saturated);
						error_count++;
					end
				end
			end
			item_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				lookup_answers.insert(lookup_answers.size(), lookup_efficiency(drive_item));
				items_accepted++;
			end
		end
	end

	// An item with every field random; callers then set what matters, so the
	// fields the operation ignores still toggle.
	function automatic lookup_item_t scrambled();
		lookup_item_t it;
		it.operation = op_codes[$urandom_range(3)];
		it.pt_low = 16'($urandom);
		it.pt_high = 16'($urandom);
		it.eta_low = 12'($urandom);
		it.eta_high = 12'($urandom);
		it.efficiency = 16'($urandom);
		it.error_low = 16'($urandom);
		it.error_high = 16'($urandom);
		it.pt = 16'($urandom);
		it.eta = 12'($urandom);
		it.variant = variant_codes[$urandom_range(3)];
		return it;
	endfunction

	task automatic send(lookup_item_t it);
		item_backlog.insert(item_backlog.size(), it);
		items_issued++;
		if (it.operation != OP_IGNORED)
			stimulus_count++;
	endtask

	task automatic send_clear();
		lookup_item_t it;
		it = scrambled();
		it.operation = OP_CLEAR;
		send(it);
		gen_bins.delete();
	endtask

	task automatic send_append(int pl, int ph, int el, int eh, int eff, int elo, int ehi);
		lookup_item_t it;
		bin_rec_t     b;
		it = scrambled();
		it.operation = OP_APPEND;
		it.pt_low = pl[15:0];
		it.pt_high = ph[15:0];
		it.eta_low = el[11:0];
		it.eta_high = eh[11:0];
		it.efficiency = eff[15:0];
		it.error_low = elo[15:0];
		it.error_high = ehi[15:0];
		send(it);
		b = '{pl, ph, el, eh, eff, elo, ehi};
		if (gen_bins.size() < TABLE_DEPTH)
			gen_bins.insert(gen_bins.size(), b);
	endtask

	task automatic send_query(int pt, int eta, logic [1:0] variant_code);
		lookup_item_t it;
		it = scrambled();
		it.operation = OP_QUERY;
		it.pt = pt[15:0];
		it.eta = eta[11:0];
		it.variant = variant_code;
		send(it);
	endtask

	// Mostly ordinary bins, a quarter of them around the current fallback pt,
	// plus empty, inverted and fully random ranges.
	task automatic send_random_bin();
		int pl;
		int ph;
		int el;
		int eh;
		int eff;
		int elo;
		int ehi;
		int fb;
		int pick;
		fb = int'(model_fallback);
		pick = $urandom_range(99);
		if (pick < 25) begin
			pl = fb - int'($urandom_range(600));
			ph = fb + 1 + int'($urandom_range(600));
		end else if (pick < 35) begin
			pl = $urandom_range(8000);
			ph = pl - int'($urandom_range(50));
		end else if (pick < 42) begin
			pl = $urandom_range(65535);
			ph = $urandom_range(65535);
		end else begin
			pl = $urandom_range(8000);
			ph = pl + 1 + int'($urandom_range(2000));
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			el = int'($urandom_range(4095)) - 2048;
			eh = int'($urandom_range(4095)) - 2048;
		end else if (pick < 18) begin
			el = int'($urandom_range(1200)) - 600;
			eh = el - int'($urandom_range(40));
		end else begin
			el = int'($urandom_range(1200)) - 600;
			eh = el + 1 + int'($urandom_range(800));
		end
		eff = $urandom_range(65535);
		elo = ($urandom_range(1) != 0) ? int'($urandom_range(65535)) : eff / 2;
		ehi = ($urandom_range(1) != 0) ? int'($urandom_range(65535)) : (65535 - eff) / 2;
		send_append(clip(pl, 0, 65535), clip(ph, 0, 65535),
			clip(el, -2048, 2047), clip(eh, -2048, 2047), eff, elo, ehi);
	endtask

	// Most query points land inside a loaded bin; some share only its eta
	// range, which steers the lookup onto the fallback path.
	task automatic send_random_query();
		bin_rec_t b;
		int       pt;
		int       eta;
		int       pick;
		pick = $urandom_range(99);
		if (gen_bins.size() != 0 && pick < 80) begin
			b = gen_bins[$urandom_range(gen_bins.size() - 1)];
			if (pick < 60 && b.pt_lo < b.pt_hi)
				pt = b.pt_lo + int'($urandom_range(b.pt_hi - b.pt_lo - 1));
			else
				pt = $urandom_range(65535);
			if (b.eta_lo < b.eta_hi)
				eta = b.eta_lo + int'($urandom_range(b.eta_hi - b.eta_lo - 1));
			else
				eta = b.eta_lo;
		end else if (pick < 90) begin
			pt = $urandom_range(9000);
			eta = int'($urandom_range(1400)) - 700;
		end else begin
			pt = $urandom_range(65535);
			eta = int'($urandom_range(4095)) - 2048;
		end
		send_query(pt, eta, ($urandom_range(99) < 5) ? VAR_ALT : variant_codes[$urandom_range(2)]);
	endtask

	// The sender stops until every issued item has been accepted and answered.
	task automatic wait_idle();
		while (items_accepted != items_issued || lookup_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_fallback(logic [15:0] setting);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= setting;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		model_fallback = setting;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	int           send_idle_by_phase[4]  = '{0, 71, 0, 23};
	int           recv_stall_by_phase[4] = '{0, 0, 71, 23};
	logic [15:0]  fallback_by_phase[4];
	int           phase;
	int           seq_len;
	lookup_item_t noise_item;

	initial begin
		fallback_by_phase = '{16'd0, 16'hFFFF, 16'($urandom), 16'($urandom_range(9000))};
		@(posedge arst_n);

		// Directed part, run with the fallback pt still at its reset value.
		// An ignored operation and a query into the empty table come first.
		noise_item = scrambled();
		noise_item.operation = OP_IGNORED;
		send(noise_item);
		send_query(150, 0, VAR_NOMINAL);
		// A narrow bin whose errors clip in both directions, a wide-eta bin
		// that holds the fallback pt, an empty pt range, a bin at the bottom
		// eta edge, and a bin with both ranges inverted.
		send_append(100, 200, -256, 256, 1000, 2000, 65000);
		send_append(5000, 6000, -2048, 2047, 65535, 0, 0);
		send_append(300, 300, 0, 100, 777, 1, 1);
		send_append(0, 65535, -2048, -2047, 0, 65535, 65535);
		send_append(65535, 0, 2047, -2048, 1234, 5, 5);
		send_query(150, 0, VAR_NOMINAL);
		send_query(150, 0, VAR_LOW);
		send_query(150, 0, VAR_HIGH);
		// Misses that fall back: nominal by eta alone, low by the fallback
		// pt, and the alternate variant code acting as nominal.
		send_query(150, 300, VAR_NOMINAL);
		send_query(50, 300, VAR_LOW);
		send_query(50, 300, VAR_ALT);
		// Extremes of the query point, including sums that land exactly on
		// the top code and a miss with no fallback at all.
		send_query(0, -2048, VAR_HIGH);
		send_query(0, -2048, VAR_LOW);
		send_query(5500, 100, VAR_HIGH);
		send_query(65535, 2047, VAR_NOMINAL);
		send_query(65535, 2047, VAR_LOW);
		// Adjustments that reach exactly zero and exactly one past the top.
		send_append(0, 65535, -2048, 2047, 16'h4000, 16'h4000, 16'hC000);
		send_query(1, 1, VAR_LOW);
		send_query(1, 1, VAR_HIGH);
		// After a clear nothing matches until new bins arrive.
		send_clear();
		send_query(150, 0, VAR_NOMINAL);
		send_append(0, 65535, -2048, 2047, 65535, 65535, 65535);
		send_query(65534, 2046, VAR_HIGH);
		wait_idle();

		// Random phases. Each one drains, sets its idling mix and a new
		// fallback pt, then runs clear/append/query sequences with some
		// scattered noise. The first phase starts by overfilling the table.
		for (phase = 0; phase < 4; phase++) begin
			wait_idle();
			send_idle_pct = send_idle_by_phase[phase];
			recv_stall_pct = recv_stall_by_phase[phase];
			write_fallback(fallback_by_phase[phase]);
			if (phase == 0) begin
				send_clear();
				repeat (TABLE_DEPTH + 3) send_random_bin();
				repeat (6) send_random_query();
			end
			while (stimulus_count < 25 + 160 * (phase + 1)) begin
				if ($urandom_range(99) < 85) begin
					send_clear();
					if ($urandom_range(99) < 8)
						seq_len = $urandom_range(TABLE_DEPTH + 4, TABLE_DEPTH - 4);
					else
						seq_len = $urandom_range(12, 1);
					repeat (seq_len) send_random_bin();
					repeat ($urandom_range(12, 4)) send_random_query();
				end else begin
					repeat ($urandom_range(4, 1)) send(scrambled());
				end
			end
		end

		// Drain, then leave room for any stray result to show up.
		wait_idle();
		repeat (80) @(posedge clk);
		if (error_count == 0 && lookup_answers.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
